// ===== src/tcce_pkg.sv =====
package tcce_pkg;

  localparam logic [2:0] FUNC_PUT    = 3'd0;
  localparam logic [2:0] FUNC_CLEAR  = 3'd1;
  localparam logic [2:0] FUNC_SETCUR = 3'd2;
  localparam logic [2:0] FUNC_READ   = 3'd3;
  localparam logic [2:0] FUNC_WRITE  = 3'd4;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_BLANK = 8'h20;

  localparam logic [7:0] TAB_STEP = 8'd8;
  localparam logic [7:0] TAB_MASK = ~8'd7;

  localparam logic [3:0] RESET_FG = 4'd7;
  localparam logic [3:0] RESET_BG = 4'd0;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FG = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG = 2'd1;

  localparam int CALC_W = 12;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] char_code;
    logic [6:0] column;
    logic [4:0] row;
    logic [7:0] cell_colour;
  } in_word_t;

  typedef struct packed {
    logic [6:0]  cursor_column;
    logic [4:0]  cursor_row;
    logic [10:0] cursor_offset;
    logic [7:0]  read_char;
    logic [7:0]  read_colour;
  } out_word_t;

  typedef struct packed {
    logic [7:0] colour;
    logic [7:0] chr;
  } cell_t;

endpackage

// ===== src/tcce_screen_store.sv =====
module tcce_screen_store #(
  parameter int DEPTH = 2000,
  parameter int AW = 11
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  tcce_pkg::cell_t wr_data,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output tcce_pkg::cell_t rd_data
);

  tcce_pkg::cell_t mem [DEPTH];
  tcce_pkg::cell_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/text_console_cell_engine_core.sv =====
// Channel  Direction  Handshake             Word
// in_      input      in_valid / in_stall   tcce_pkg::in_word_t
// out_     output     out_valid / out_stall tcce_pkg::out_word_t
// cfg_     input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// Put character, set cursor, read and write cell pass an execute and an emit state, and
// the next word is taken in the cycle its result is registered. Clear and any put that
// scrolls walk the whole screen store through its single write port, one cell a cycle.
// After reset the store is filled with blanks by the same walk, while in_stall stays
// high. A result held in the output register stalls the engine in its emit state, so
// in_stall stays high and the next word waits until the output slot is free.
module text_console_cell_engine_core #(
  parameter int COLUMNS = 80,
  parameter int ROWS = 25
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  tcce_pkg::in_word_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output tcce_pkg::out_word_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tcce_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [3:0]                       cfg_data
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW = $clog2(CELLS);
  localparam int MOVE_CNT = CELLS - COLUMNS;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EXEC  = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;
  localparam logic [1:0] ST_SWEEP = 2'd3;

  logic [1:0]          state_r, state_nxt;
  tcce_pkg::in_word_t  in_r, in_nxt;
  logic [6:0]          col_r, col_nxt;
  logic [4:0]          row_r, row_nxt;
  logic [3:0]          fg_r, fg_nxt;
  logic [3:0]          bg_r, bg_nxt;
  logic                out_valid_r, out_valid_nxt;
  tcce_pkg::out_word_t out_r, out_nxt;
  logic [AW-1:0]       sweep_r, sweep_nxt;
  logic                move_r, move_nxt;
  logic                emit_r, emit_nxt;
  logic [7:0]          fill_colour_r, fill_colour_nxt;
  logic                pend_valid_r, pend_valid_nxt;
  logic [AW-1:0]       pend_addr_r, pend_addr_nxt;
  logic                pend_mem_r, pend_mem_nxt;
  tcce_pkg::cell_t     pend_data_r, pend_data_nxt;
  logic                rd_hit_r, rd_hit_nxt;

  logic                slot_free;
  logic                in_accept;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  tcce_pkg::cell_t     rd_data;
  tcce_pkg::cell_t     wr_data;
  logic [7:0]          cur_colour;
  logic                use_target;
  logic [6:0]          col_sel;
  logic [4:0]          row_sel;
  logic [tcce_pkg::CALC_W-1:0] base_calc;
  logic [tcce_pkg::CALC_W-1:0] off_calc;
  logic                target_ok;
  logic [7:0]          tab_pos;
  logic [6:0]          col_inc;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == ST_IDLE) || ((state_r == ST_EMIT) && slot_free));
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data = out_r;

  assign cur_colour = {bg_r, fg_r};
  assign use_target = (in_r.func == tcce_pkg::FUNC_READ) || (in_r.func == tcce_pkg::FUNC_WRITE);
  assign col_sel = use_target ? in_r.column : col_r;
  assign row_sel = use_target ? in_r.row : row_r;
  assign base_calc = tcce_pkg::CALC_W'(row_sel) * tcce_pkg::CALC_W'(COLUMNS)
                   + tcce_pkg::CALC_W'(col_sel);
  assign off_calc = tcce_pkg::CALC_W'(row_r) * tcce_pkg::CALC_W'(COLUMNS)
                  + tcce_pkg::CALC_W'(col_r);
  assign target_ok = (in_r.column < 7'(COLUMNS)) && (in_r.row < 5'(ROWS));
  assign tab_pos = ({1'b0, col_r} + tcce_pkg::TAB_STEP) & tcce_pkg::TAB_MASK;
  assign col_inc = col_r + 7'd1;

  assign wr_data = pend_mem_r ? rd_data : pend_data_r;

  tcce_screen_store #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (pend_valid_r),
    .wr_addr (pend_addr_r),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    logic bump;
    state_nxt = state_r;
    in_nxt = in_accept ? in_data : in_r;
    col_nxt = col_r;
    row_nxt = row_r;
    fg_nxt = fg_r;
    bg_nxt = bg_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt = out_r;
    sweep_nxt = sweep_r;
    move_nxt = move_r;
    emit_nxt = emit_r;
    fill_colour_nxt = fill_colour_r;
    pend_valid_nxt = 1'b0;
    pend_addr_nxt = pend_addr_r;
    pend_mem_nxt = 1'b0;
    pend_data_nxt = pend_data_r;
    rd_hit_nxt = rd_hit_r;
    rd_en = 1'b0;
    rd_addr = '0;
    bump = 1'b0;

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tcce_pkg::CFG_FG: fg_nxt = cfg_data;
        tcce_pkg::CFG_BG: bg_nxt = cfg_data;
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_EMIT;
        rd_hit_nxt = 1'b0;
        case (in_r.func)
          tcce_pkg::FUNC_PUT: begin
            if (in_r.char_code == tcce_pkg::CH_LF) begin
              col_nxt = '0;
              bump = 1'b1;
            end else if (in_r.char_code == tcce_pkg::CH_CR) begin
              col_nxt = '0;
            end else if (in_r.char_code == tcce_pkg::CH_BS) begin
              if (col_r != '0) begin
                col_nxt = col_r - 7'd1;
                pend_valid_nxt = 1'b1;
                pend_addr_nxt = base_calc[AW-1:0] - AW'(1);
                pend_data_nxt = '{colour: cur_colour, chr: tcce_pkg::CH_BLANK};
              end
            end else if (in_r.char_code == tcce_pkg::CH_TAB) begin
              if (tab_pos >= 8'(COLUMNS)) begin
                col_nxt = '0;
                bump = 1'b1;
              end else begin
                col_nxt = tab_pos[6:0];
              end
            end else if (in_r.char_code >= tcce_pkg::CH_BLANK) begin
              pend_valid_nxt = 1'b1;
              pend_addr_nxt = base_calc[AW-1:0];
              pend_data_nxt = '{colour: cur_colour, chr: in_r.char_code};
              if (col_inc >= 7'(COLUMNS)) begin
                col_nxt = '0;
                bump = 1'b1;
              end else begin
                col_nxt = col_inc;
              end
            end
            if (bump) begin
              if (row_r == 5'(ROWS - 1)) begin
                state_nxt = ST_SWEEP;
                sweep_nxt = '0;
                move_nxt = 1'b1;
                emit_nxt = 1'b1;
                fill_colour_nxt = cur_colour;
              end else begin
                row_nxt = row_r + 5'd1;
              end
            end
          end
          tcce_pkg::FUNC_CLEAR: begin
            col_nxt = '0;
            row_nxt = '0;
            state_nxt = ST_SWEEP;
            sweep_nxt = '0;
            move_nxt = 1'b0;
            emit_nxt = 1'b1;
            fill_colour_nxt = cur_colour;
          end
          tcce_pkg::FUNC_SETCUR: begin
            col_nxt = (in_r.column < 7'(COLUMNS)) ? in_r.column : 7'(COLUMNS - 1);
            row_nxt = (in_r.row < 5'(ROWS)) ? in_r.row : 5'(ROWS - 1);
          end
          tcce_pkg::FUNC_READ: begin
            rd_en = target_ok;
            rd_addr = base_calc[AW-1:0];
            rd_hit_nxt = target_ok;
          end
          tcce_pkg::FUNC_WRITE: begin
            if (target_ok) begin
              pend_valid_nxt = 1'b1;
              pend_addr_nxt = base_calc[AW-1:0];
              pend_data_nxt = '{colour: in_r.cell_colour, chr: in_r.char_code};
            end
          end
          default: ;
        endcase
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_nxt.cursor_column = col_r;
          out_nxt.cursor_row = row_r;
          out_nxt.cursor_offset = off_calc[10:0];
          out_nxt.read_char = rd_hit_r ? rd_data.chr : 8'd0;
          out_nxt.read_colour = rd_hit_r ? rd_data.colour : 8'd0;
          state_nxt = in_accept ? ST_EXEC : ST_IDLE;
        end
      end
      ST_SWEEP: begin
        pend_valid_nxt = 1'b1;
        pend_addr_nxt = sweep_r;
        pend_data_nxt = '{colour: fill_colour_r, chr: tcce_pkg::CH_BLANK};
        if (move_r && (sweep_r < AW'(MOVE_CNT))) begin
          rd_en = 1'b1;
          rd_addr = sweep_r + AW'(COLUMNS);
          pend_mem_nxt = 1'b1;
        end
        if (sweep_r == AW'(CELLS - 1)) begin
          sweep_nxt = '0;
          state_nxt = emit_r ? ST_EMIT : ST_IDLE;
        end else begin
          sweep_nxt = sweep_r + AW'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SWEEP;
      col_r <= '0;
      row_r <= '0;
      fg_r <= tcce_pkg::RESET_FG;
      bg_r <= tcce_pkg::RESET_BG;
      out_valid_r <= 1'b0;
      sweep_r <= '0;
      move_r <= 1'b0;
      emit_r <= 1'b0;
      fill_colour_r <= {tcce_pkg::RESET_BG, tcce_pkg::RESET_FG};
      pend_valid_r <= 1'b0;
      rd_hit_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
      fg_r <= fg_nxt;
      bg_r <= bg_nxt;
      out_valid_r <= out_valid_nxt;
      sweep_r <= sweep_nxt;
      move_r <= move_nxt;
      emit_r <= emit_nxt;
      fill_colour_r <= fill_colour_nxt;
      pend_valid_r <= pend_valid_nxt;
      rd_hit_r <= rd_hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r <= in_nxt;
    out_r <= out_nxt;
    pend_addr_r <= pend_addr_nxt;
    pend_mem_r <= pend_mem_nxt;
    pend_data_r <= pend_data_nxt;
  end

endmodule
